@@ sv/assert_macros.svh @@
// Assertion helpers for the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ctl_pkg.sv @@
`default_nettype none

package ctl_pkg;

    typedef enum logic [1:0] {
        CLS_PLAIN = 2'd0,
        CLS_WS    = 2'd1,
        CLS_PUNCT = 2'd2,
        CLS_QUOTE = 2'd3
    } cls_t;

    // class table write port
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        cls_t       cls;
    } tbl_wr_t;

    localparam logic [7:0] WS_LO    = 8'd9;
    localparam logic [7:0] WS_HI    = 8'd13;
    localparam logic [7:0] WS_SPACE = 8'd32;

endpackage

`default_nettype wire

@@ sv/ctl_class_table.sv @@
`default_nettype none

module ctl_class_table
    import ctl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tbl_wr_t    wr,
    input  wire logic       rd_en,
    input  wire logic [7:0] rd_addr,
    output cls_t            rd_cls
);

    cls_t         mem [256];
    logic [255:0] written_reg;
    cls_t         mem_q_reg;
    logic         written_q_reg;
    cls_t         dflt_q_reg;
    cls_t         dflt;

    // entries never written read as the power-up classes
    always_comb
    begin
        if ((rd_addr >= WS_LO && rd_addr <= WS_HI) || rd_addr == WS_SPACE)
            dflt = CLS_WS;
        else
            dflt = CLS_PLAIN;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.cls;
        if (rd_en)
        begin
            mem_q_reg  <= mem[rd_addr];
            dflt_q_reg <= dflt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                written_reg[wr.addr] <= 1'b1;
            if (rd_en)
                written_q_reg <= written_reg[rd_addr];
        end
    end

    assign rd_cls = written_q_reg ? mem_q_reg : dflt_q_reg;

endmodule

`default_nettype wire

@@ sv/configurable_token_lexer_core.sv @@
// Byte-stream tokenizer with a programmable class table and escape decoding.
// s_axis carries one item per transfer: tuser selects a character, a class
// table write (tdata[7:0] index, tdata[9:8] class) or end of input.
// m_axis returns token bytes; tlast marks the final byte of a token, tuser
// gives byte_valid and the token kind. An empty quoted token is a single
// transfer with byte_valid low.
// cfg writes escape_enable (index 0) and escape_char (index 1); write only
// while the block is idle. cfg_ready is always high.
// An item passes the class table read, then the lexer state update, which
// loads its results into the output register.
// Throughput: one item per cycle while each item yields at most one result
// and m_axis_tready is high. Two or three results of one item hold the output
// register until sent, one per cycle, and stall the next item with results.
// Reset clears the lexer state and restores the power-up class table
// (9 to 13 and 32 whitespace, else plain) through per-entry written flags.
// When m_axis_tready is low the output register holds, an item with results
// waits in the update stage and s_axis_tready drops while it waits there.
`default_nettype none

module configurable_token_lexer_core
    import ctl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [7:0] char_code, [9:8] class_code
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]       m_axis_tuser,  // [0] byte_valid, [2:1] token_kind
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

`include "assert_macros.svh"

    localparam logic [1:0] FUNC_CHAR  = 2'd0;
    localparam logic [1:0] FUNC_CLASS = 2'd1;
    localparam logic [1:0] FUNC_EOI   = 2'd2;

    localparam logic CFG_ESC_EN   = 1'b0;
    localparam logic CFG_ESC_CHAR = 1'b1;

    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_QUOTED = 2'd1;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_0    = "0";
    localparam logic [7:0] CH_7    = "7";
    localparam logic [7:0] CH_9    = "9";
    localparam logic [7:0] CH_UA   = "A";
    localparam logic [7:0] CH_UF   = "F";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_LF   = "f";
    localparam logic [7:0] CH_X    = "x";
    localparam logic [7:0] CH_B    = "b";
    localparam logic [7:0] CH_N    = "n";
    localparam logic [7:0] CH_R    = "r";
    localparam logic [7:0] CH_T    = "t";
    localparam logic [7:0] CH_V    = "v";
    localparam logic [7:0] HEX_UP_OFS = CH_UA - 8'd10;
    localparam logic [7:0] HEX_LO_OFS = CH_LA - 8'd10;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_ESC    = 3'd3,
        MODE_OCT    = 3'd4,
        MODE_HEX    = 3'd5
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] token_kind;
        logic       token_last;
    } res_t;

    typedef struct packed {
        lex_mode_t       mode;
        logic [7:0]      oq;
        logic [7:0]      ev;
        logic [1:0]      od;
        logic [7:0]      hb;
        logic            hv;
        logic [1:0]      kind;
        res_t [2:0]      res;
        logic [1:0]      cnt;
    } lx_t;

    // ---------------------------------------------------------------- step
    function automatic lx_t emit(lx_t s, logic [7:0] b, logic v, logic [1:0] k,
                                 logic l);
        lx_t r;
        r = s;
        if (r.cnt != 2'd3)
        begin
            r.res[r.cnt] = '{out_byte: b, byte_valid: v, token_kind: k, token_last: l};
            r.cnt        = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic lx_t push(lx_t s, logic [7:0] c);
        lx_t r;
        r = s;
        if (r.hv)
            r = emit(r, r.hb, 1'b1, r.kind, 1'b0);
        r.hb = c;
        r.hv = 1'b1;
        return r;
    endfunction

    function automatic lx_t end_tok(lx_t s);
        lx_t r;
        r = s;
        if (r.hv)
            r = emit(r, r.hb, 1'b1, r.kind, 1'b1);
        else if (r.kind == KIND_QUOTED)
            r = emit(r, 8'd0, 1'b0, KIND_QUOTED, 1'b1);
        r.hv   = 1'b0;
        r.mode = MODE_IDLE;
        return r;
    endfunction

    function automatic lx_t idle_ch(lx_t s, logic [7:0] c, cls_t cls, logic esc);
        lx_t r;
        r      = s;
        r.mode = MODE_IDLE;
        unique case (cls)
            CLS_WS: ;
            CLS_PUNCT: r = emit(r, c, 1'b1, KIND_PUNCT, 1'b1);
            CLS_QUOTE:
            begin
                r.hv   = 1'b0;
                r.oq   = c;
                r.kind = KIND_QUOTED;
                r.mode = MODE_QUOTED;
            end
            default:
            begin
                r.hv   = 1'b0;
                r.kind = KIND_PLAIN;
                if (esc)
                    r.mode = MODE_ESC;
                else
                begin
                    r.mode = MODE_PLAIN;
                    r      = push(r, c);
                end
            end
        endcase
        return r;
    endfunction

    function automatic lx_t body_ch(lx_t s, logic [7:0] c, cls_t cls, logic esc);
        lx_t r;
        r = s;
        if (r.kind == KIND_QUOTED)
        begin
            r.mode = MODE_QUOTED;
            if (c == r.oq)
                r = end_tok(r);
            else if (esc)
                r.mode = MODE_ESC;
            else if (c == CH_NL)
                r = idle_ch(end_tok(r), c, cls, esc);
            else
                r = push(r, c);
        end
        else
        begin
            r.mode = MODE_PLAIN;
            if (esc)
                r.mode = MODE_ESC;
            else if (cls == CLS_PLAIN)
                r = push(r, c);
            else
                r = idle_ch(end_tok(r), c, cls, esc);
        end
        return r;
    endfunction

    function automatic lx_t esc_ch(lx_t s, logic [7:0] c);
        lx_t r;
        r      = s;
        r.mode = (r.kind == KIND_QUOTED) ? MODE_QUOTED : MODE_PLAIN;
        case (c)
            CH_LA: r = push(r, 8'd7);
            CH_B:  r = push(r, 8'd8);
            CH_LF: r = push(r, 8'd12);
            CH_N:  r = push(r, 8'd10);
            CH_R:  r = push(r, 8'd13);
            CH_T:  r = push(r, 8'd9);
            CH_V:  r = push(r, 8'd11);
            CH_X:
            begin
                r.ev   = 8'd0;
                r.mode = MODE_HEX;
            end
            default:
            begin
                if (c >= CH_0 && c <= CH_7)
                begin
                    r.ev   = {5'd0, c[2:0]};
                    r.od   = 2'd1;
                    r.mode = MODE_OCT;
                end
                else
                    r = push(r, c);
            end
        endcase
        return r;
    endfunction

    // --------------------------------------------------------- stage regs
    logic       s1_valid_reg;
    logic [1:0] s1_func_reg;
    logic [7:0] s1_char_reg;
    cls_t       s1_cls;
    logic       s1_fire;
    logic       in_xfer;
    logic       out_xfer;
    logic       bun_done;
    tbl_wr_t    tbl_wr;

    lex_mode_t  mode_reg;
    logic [7:0] open_quote_reg;
    logic [7:0] esc_val_reg;
    logic [1:0] oct_cnt_reg;
    logic [7:0] held_byte_reg;
    logic       held_valid_reg;
    logic [1:0] kind_reg;
    logic       esc_en_reg;
    logic [7:0] esc_char_reg;

    res_t [2:0] bun_res_reg;
    logic [1:0] bun_cnt_reg;
    logic [1:0] bun_idx_reg;

    lx_t        lx_cur;
    lx_t        lx_next;
    logic       esc_hit;
    logic [7:0] hex_d;
    logic       hex_ok;
    logic [1:0] od_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg   <= 1'b0;
            esc_char_reg <= 8'd92;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ESC_EN:   esc_en_reg   <= cfg_data[0];
                CFG_ESC_CHAR: esc_char_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // read stage: table lookup, class writes take effect at transfer time
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign tbl_wr.en     = in_xfer && (s_axis_tuser == FUNC_CLASS);
    assign tbl_wr.addr   = s_axis_tdata[7:0];
    assign tbl_wr.cls    = cls_t'(s_axis_tdata[9:8]);

    ctl_class_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_en   (in_xfer),
        .rd_addr (s_axis_tdata[7:0]),
        .rd_cls  (s1_cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg <= s_axis_tuser;
            s1_char_reg <= s_axis_tdata[7:0];
        end
    end

    // update stage
    assign esc_hit = esc_en_reg && (s1_char_reg == esc_char_reg);
    assign od_inc  = oct_cnt_reg + 2'd1;

    always_comb
    begin
        hex_ok = 1'b1;
        if (s1_char_reg >= CH_0 && s1_char_reg <= CH_9)
            hex_d = s1_char_reg - CH_0;
        else if (s1_char_reg >= CH_UA && s1_char_reg <= CH_UF)
            hex_d = s1_char_reg - HEX_UP_OFS;
        else if (s1_char_reg >= CH_LA && s1_char_reg <= CH_LF)
            hex_d = s1_char_reg - HEX_LO_OFS;
        else
        begin
            hex_d  = 8'd0;
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        lx_cur = '{mode: mode_reg, oq: open_quote_reg, ev: esc_val_reg,
                   od: oct_cnt_reg, hb: held_byte_reg, hv: held_valid_reg,
                   kind: kind_reg, res: '0, cnt: 2'd0};
        lx_next = lx_cur;
        if (s1_func_reg == FUNC_CHAR)
        begin
            case (mode_reg)
                MODE_PLAIN, MODE_QUOTED:
                    lx_next = body_ch(lx_cur, s1_char_reg, s1_cls, esc_hit);
                MODE_ESC:
                    lx_next = esc_ch(lx_cur, s1_char_reg);
                MODE_OCT:
                begin
                    if (s1_char_reg >= CH_0 && s1_char_reg <= CH_7)
                    begin
                        lx_next.ev = {esc_val_reg[4:0], s1_char_reg[2:0]};
                        lx_next.od = od_inc;
                        if (od_inc == 2'd3 || od_inc == 2'd0)
                        begin
                            lx_next.od   = 2'd0;
                            lx_next.mode = (kind_reg == KIND_QUOTED) ? MODE_QUOTED
                                                                     : MODE_PLAIN;
                            lx_next      = push(lx_next, lx_next.ev);
                        end
                    end
                    else
                    begin
                        lx_next.od = 2'd0;
                        lx_next    = body_ch(push(lx_next, esc_val_reg), s1_char_reg,
                                             s1_cls, esc_hit);
                    end
                end
                MODE_HEX:
                begin
                    if (hex_ok)
                        lx_next.ev = {esc_val_reg[3:0], hex_d[3:0]};
                    else
                        lx_next = body_ch(push(lx_cur, esc_val_reg), s1_char_reg,
                                          s1_cls, esc_hit);
                end
                default:
                    lx_next = idle_ch(lx_cur, s1_char_reg, s1_cls, esc_hit);
            endcase
        end
        else if (s1_func_reg == FUNC_EOI)
        begin
            case (mode_reg)
                MODE_OCT, MODE_HEX:
                    lx_next = end_tok(push(lx_cur, esc_val_reg));
                MODE_ESC, MODE_PLAIN, MODE_QUOTED:
                    lx_next = end_tok(lx_cur);
                default: ;
            endcase
            lx_next.od   = 2'd0;
            lx_next.hv   = 1'b0;
            lx_next.mode = MODE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            open_quote_reg <= 8'd0;
            esc_val_reg    <= 8'd0;
            oct_cnt_reg    <= 2'd0;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            kind_reg       <= KIND_PLAIN;
        end
        else if (s1_fire)
        begin
            mode_reg       <= lx_next.mode;
            open_quote_reg <= lx_next.oq;
            esc_val_reg    <= lx_next.ev;
            oct_cnt_reg    <= lx_next.od;
            held_byte_reg  <= lx_next.hb;
            held_valid_reg <= lx_next.hv;
            kind_reg       <= lx_next.kind;
        end
    end

    // output register: up to three results of one item, sent in order
    assign m_axis_tvalid = (bun_cnt_reg != 2'd0);
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign bun_done      = out_xfer && (bun_idx_reg == bun_cnt_reg - 2'd1);
    assign s1_fire       = s1_valid_reg &&
                           (bun_cnt_reg == 2'd0 || bun_done || lx_next.cnt == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bun_cnt_reg <= 2'd0;
            bun_idx_reg <= 2'd0;
        end
        else if (s1_fire && lx_next.cnt != 2'd0)
        begin
            bun_cnt_reg <= lx_next.cnt;
            bun_idx_reg <= 2'd0;
        end
        else if (bun_done)
        begin
            bun_cnt_reg <= 2'd0;
            bun_idx_reg <= 2'd0;
        end
        else if (out_xfer)
            bun_idx_reg <= bun_idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && lx_next.cnt != 2'd0)
            bun_res_reg <= lx_next.res;
    end

    assign m_axis_tdata = bun_res_reg[bun_idx_reg].out_byte;
    assign m_axis_tuser = {bun_res_reg[bun_idx_reg].token_kind,
                           bun_res_reg[bun_idx_reg].byte_valid};
    assign m_axis_tlast = bun_res_reg[bun_idx_reg].token_last;

    // ---------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_idx_in_range, (!rst_n || !m_axis_tvalid || bun_idx_reg < bun_cnt_reg), "output index beyond result count")
    `ASSERT_CLK(a_s1_holds, (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_char_reg) && $stable(s1_func_reg)), "stalled item lost in update stage")
    `ASSERT_CLK(a_held_in_token, held_valid_reg |-> (mode_reg != MODE_IDLE), "held byte outside a token")
    `ASSERT_CLK(a_bundle_kept, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(bun_idx_reg)), "pending result dropped")

endmodule

`default_nettype wire
